>>> rtl/core/svpwm_pkg.sv
package svpwm_pkg;

   // Q0.16 approximation of 1/sqrt(3)
   localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
   localparam int unsigned QFRAC = 16;
   localparam logic [2:0] SECTOR_ZERO_BUS = 3'd1;

   // configuration register indexes
   localparam logic [0:0] REG_PWM_PERIOD = 1'b0;

   typedef enum logic [2:0] {
      SEC_1 = 3'd1,
      SEC_2 = 3'd2,
      SEC_3 = 3'd3,
      SEC_4 = 3'd4,
      SEC_5 = 3'd5,
      SEC_6 = 3'd6
   } sector_type;

endpackage

>>> rtl/core/svpwm_if.sv
interface svpwm_req_if #(
   parameter int VOLT_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [VOLT_WIDTH-1:0] v_alpha;
   logic signed [VOLT_WIDTH-1:0] v_beta;
   logic [VOLT_WIDTH-1:0]        v_bus;

   modport source (output valid, v_alpha, v_beta, v_bus, input ready);
   modport sink (input valid, v_alpha, v_beta, v_bus, output ready);
endinterface

interface svpwm_rsp_if #(
   parameter int PERIOD_WIDTH = 16
);
   logic                    valid;
   logic                    ready;
   logic [PERIOD_WIDTH-1:0] duty_u;
   logic [PERIOD_WIDTH-1:0] duty_v;
   logic [PERIOD_WIDTH-1:0] duty_w;
   logic [2:0]              sector;
   logic                    bus_zero;

   modport source (output valid, duty_u, duty_v, duty_w, sector, bus_zero, input ready);
   modport sink (input valid, duty_u, duty_v, duty_w, sector, bus_zero, output ready);
endinterface

>>> rtl/core/svpwm_duty_calc.sv
// Space vector PWM duty calculator.
// req channel: v_alpha, v_beta (signed) and v_bus (unsigned) per item.
// rsp channel: duty_u/v/w clamped to 0..pwm_period, sector 1..6, bus_zero.
// csr port: APB-style, register 0 at address 0 is pwm_period (reset 2048).
// A zero bus gives all duties 0, sector 1 and bus_zero set.
// The divider produces one quotient bit per stage and is followed by the
// sector, time and duty stages, the last of which is the output register.
// Throughput: one item per cycle while the pipeline advances, which it does
// whenever the output register is empty or being taken.
// When the receiver stalls the pipeline freezes in place; req_ready drops
// while a result waits and the pipeline is stopped. Synchronous reset
// clears all valid bits and returns pwm_period to 2048.
// pwm_period should only change while no item is in flight.
module svpwm_duty_calc #(
   parameter int VOLT_WIDTH   = 16,
   parameter int PERIOD_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   svpwm_req_if.sink           req,
   svpwm_rsp_if.source         rsp,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [1:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   logic [PERIOD_WIDTH-1:0] period_ff;
   logic                    enable;
   logic                    dv_valid, dq_zero;
   logic signed [18:0]      qa, qb;

   // register file
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_WIDTH'(2048);
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[1:1] == svpwm_pkg::REG_PWM_PERIOD) begin
         period_ff <= csr_pwdata[PERIOD_WIDTH-1:0];
      end
   end
   assign csr_prdata = (csr_paddr[1:1] == svpwm_pkg::REG_PWM_PERIOD) ?
                       32'(period_ff) : '0;

   // pipeline moves when output slot free or drained
   assign enable    = !rsp.valid || rsp.ready;
   assign req.ready = enable;

   svpwm_div #(.VOLT_WIDTH(VOLT_WIDTH)) u_div (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(req.valid), .v_a(req.v_alpha), .v_b(req.v_beta), .v_bus(req.v_bus),
      .out_valid(dv_valid), .q_a(qa), .q_b(qb), .out_bus_zero(dq_zero)
   );

   svpwm_time #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_time (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(dv_valid), .q_a(qa), .q_b(qb), .in_bus_zero(dq_zero),
      .period(period_ff), .out_valid(rsp.valid),
      .duty_u(rsp.duty_u), .duty_v(rsp.duty_v), .duty_w(rsp.duty_w),
      .sector(rsp.sector), .bus_zero(rsp.bus_zero)
   );
endmodule

>>> rtl/core/svpwm_div.sv
// Pipelined restoring divider: (|v| << 16) / bus, one quotient bit per stage,
// two operands divided in lock step. Sign handling and Q2.16 saturation at the end.
module svpwm_div #(
   parameter int VOLT_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic signed [VOLT_WIDTH-1:0] v_a,
   input  logic signed [VOLT_WIDTH-1:0] v_b,
   input  logic [VOLT_WIDTH-1:0]        v_bus,
   output logic                         out_valid,
   output logic signed [18:0]           q_a,
   output logic signed [18:0]           q_b,
   output logic                         out_bus_zero
);
   localparam int NW = VOLT_WIDTH + svpwm_pkg::QFRAC;   // dividend width
   localparam int ST = NW;                             // one bit per stage
   localparam int RW = VOLT_WIDTH + 1;                  // partial remainder width

   logic [ST:0]            vld_ff;
   logic [NW-1:0]          na_ff [ST+1];
   logic [NW-1:0]          nb_ff [ST+1];
   logic [RW-1:0]          ra_ff [ST+1];
   logic [RW-1:0]          rb_ff [ST+1];
   logic [VOLT_WIDTH-1:0]  d_ff  [ST+1];
   logic [ST:0]            sa_ff;
   logic [ST:0]            sb_ff;

   logic [VOLT_WIDTH-1:0]  mag_a_in;
   logic [VOLT_WIDTH-1:0]  mag_b_in;

   assign mag_a_in = v_a[VOLT_WIDTH-1] ? VOLT_WIDTH'(-v_a) : VOLT_WIDTH'(v_a);
   assign mag_b_in = v_b[VOLT_WIDTH-1] ? VOLT_WIDTH'(-v_b) : VOLT_WIDTH'(v_b);

   // stage 0 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
      end
      if (enable) begin
         na_ff[0] <= {mag_a_in, {svpwm_pkg::QFRAC{1'b0}}};
         nb_ff[0] <= {mag_b_in, {svpwm_pkg::QFRAC{1'b0}}};
         ra_ff[0] <= '0;
         rb_ff[0] <= '0;
         d_ff[0]  <= v_bus;
         sa_ff[0] <= v_a[VOLT_WIDTH-1];
         sb_ff[0] <= v_b[VOLT_WIDTH-1];
      end
   end

   // one restoring step per stage; quotient bits shift into n
   for (genvar s = 0; s < ST; s++) begin : g_step
      logic [RW-1:0] tra_in, trb_in;
      logic [RW:0]   dfa_in, dfb_in;
      assign tra_in = {ra_ff[s][RW-2:0], na_ff[s][NW-1]};
      assign trb_in = {rb_ff[s][RW-2:0], nb_ff[s][NW-1]};
      assign dfa_in = {1'b0, tra_in} - {2'b0, d_ff[s]};
      assign dfb_in = {1'b0, trb_in} - {2'b0, d_ff[s]};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (enable) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (enable) begin
            ra_ff[s+1] <= dfa_in[RW] ? tra_in : dfa_in[RW-1:0];
            rb_ff[s+1] <= dfb_in[RW] ? trb_in : dfb_in[RW-1:0];
            na_ff[s+1] <= {na_ff[s][NW-2:0], ~dfa_in[RW]};
            nb_ff[s+1] <= {nb_ff[s][NW-2:0], ~dfb_in[RW]};
            d_ff[s+1]  <= d_ff[s];
            sa_ff[s+1] <= sa_ff[s];
            sb_ff[s+1] <= sb_ff[s];
         end
      end
   end

   // saturate magnitude and apply sign
   function automatic logic signed [18:0] sat_q(input logic [NW-1:0] q, input logic neg);
      logic [NW:0] lim;
      logic [17:0] m;
      lim = neg ? (NW+1)'(131072) : (NW+1)'(131071);
      m = ({1'b0, q} > lim) ? lim[17:0] : q[17:0];
      return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   assign out_valid    = vld_ff[ST];
   assign q_a          = sat_q(na_ff[ST], sa_ff[ST]);
   assign q_b          = sat_q(nb_ff[ST], sb_ff[ST]);
   assign out_bus_zero = (d_ff[ST] == '0);
endmodule

>>> rtl/core/svpwm_time.sv
// Sector search, active-vector times and centred, clamped duties.
// Stages: multiply, sector and time sums, period product, centring, clamp.
module svpwm_time #(
   parameter int PERIOD_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  logic signed [18:0]        q_a,
   input  logic signed [18:0]        q_b,
   input  logic                      in_bus_zero,
   input  logic [PERIOD_WIDTH-1:0]   period,
   output logic                      out_valid,
   output logic [PERIOD_WIDTH-1:0]   duty_u,
   output logic [PERIOD_WIDTH-1:0]   duty_v,
   output logic [PERIOD_WIDTH-1:0]   duty_w,
   output logic [2:0]                sector,
   output logic                      bus_zero
);
   localparam int XW = 40;                      // Q.32 working width
   localparam int DW = PERIOD_WIDTH + 4;        // signed duty width
   localparam int PW = 36 + PERIOD_WIDTH;

   // stage 1: a<<16 and K*b
   logic [4:0]               vld_ff;
   logic signed [XW-1:0]     a1_ff, kb1_ff;
   logic                     z1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
      if (enable) begin
         a1_ff  <= XW'(q_a) <<< 16;
         kb1_ff <= XW'(q_b) * XW'($signed({1'b0, svpwm_pkg::INV_SQRT3_Q16}));
         z1_ff  <= in_bus_zero;
      end
   end

   // stage 2: sector and the two Q.32 times
   svpwm_pkg::sector_type sec_in;
   logic signed [XW-1:0]  x1_in, x2_in;
   always_comb begin
      if (kb1_ff >= 0) begin
         if (a1_ff >= 0) sec_in = (kb1_ff > a1_ff) ? svpwm_pkg::SEC_2 : svpwm_pkg::SEC_1;
         else sec_in = (-kb1_ff > a1_ff) ? svpwm_pkg::SEC_3 : svpwm_pkg::SEC_2;
      end else begin
         if (a1_ff >= 0) sec_in = (-kb1_ff > a1_ff) ? svpwm_pkg::SEC_5 : svpwm_pkg::SEC_6;
         else sec_in = (kb1_ff > a1_ff) ? svpwm_pkg::SEC_4 : svpwm_pkg::SEC_5;
      end
      case (sec_in)
         svpwm_pkg::SEC_1: begin
            x1_in = a1_ff - kb1_ff;  x2_in = kb1_ff <<< 1;
         end
         svpwm_pkg::SEC_2: begin
            x1_in = a1_ff + kb1_ff;  x2_in = kb1_ff - a1_ff;
         end
         svpwm_pkg::SEC_3: begin
            x1_in = kb1_ff <<< 1;    x2_in = -a1_ff - kb1_ff;
         end
         svpwm_pkg::SEC_4: begin
            x1_in = kb1_ff - a1_ff;  x2_in = -(kb1_ff <<< 1);
         end
         svpwm_pkg::SEC_5: begin
            x1_in = -a1_ff - kb1_ff; x2_in = a1_ff - kb1_ff;
         end
         default: begin
            x1_in = -(kb1_ff <<< 1); x2_in = a1_ff + kb1_ff;
         end
      endcase
   end

   svpwm_pkg::sector_type sec2_ff;
   logic [XW-1:0]         m1_ff, m2_ff;
   logic                  n1_ff, n2_ff, z2_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         sec2_ff <= sec_in;
         n1_ff   <= x1_in[XW-1];
         n2_ff   <= x2_in[XW-1];
         m1_ff   <= x1_in[XW-1] ? XW'(-x1_in) : XW'(x1_in);
         m2_ff   <= x2_in[XW-1] ? XW'(-x2_in) : XW'(x2_in);
         z2_ff   <= z1_ff;
      end
   end

   // stage 3: scale by period, truncate toward zero
   logic [PW-1:0]          p1_in, p2_in;
   logic signed [DW-1:0]   t1_ff, t2_ff;
   svpwm_pkg::sector_type  sec3_ff;
   logic                   z3_ff;
   assign p1_in = PW'(m1_ff[35:0]) * PW'(period);
   assign p2_in = PW'(m2_ff[35:0]) * PW'(period);
   always_ff @(posedge clock) begin
      if (enable) begin
         t1_ff   <= n1_ff ? -$signed(DW'(p1_in >> 32)) : $signed(DW'(p1_in >> 32));
         t2_ff   <= n2_ff ? -$signed(DW'(p2_in >> 32)) : $signed(DW'(p2_in >> 32));
         sec3_ff <= sec2_ff;
         z3_ff   <= z2_ff;
      end
   end

   // stage 4: centring
   logic signed [DW-1:0]  lead_in;
   logic signed [DW-1:0]  du_in, dv_in, dw_in;
   logic signed [DW-1:0]  du_ff, dv_ff, dw_ff;
   svpwm_pkg::sector_type sec4_ff;
   logic                  z4_ff;
   assign lead_in = ($signed(DW'({1'b0, period})) + t1_ff + t2_ff) >>> 1;
   always_comb begin
      case (sec3_ff)
         svpwm_pkg::SEC_1: begin
            du_in = lead_in; dv_in = du_in - t1_ff; dw_in = dv_in - t2_ff;
         end
         svpwm_pkg::SEC_2: begin
            dv_in = lead_in; du_in = dv_in - t2_ff; dw_in = du_in - t1_ff;
         end
         svpwm_pkg::SEC_3: begin
            dv_in = lead_in; dw_in = dv_in - t1_ff; du_in = dw_in - t2_ff;
         end
         svpwm_pkg::SEC_4: begin
            dw_in = lead_in; dv_in = dw_in - t2_ff; du_in = dv_in - t1_ff;
         end
         svpwm_pkg::SEC_5: begin
            dw_in = lead_in; du_in = dw_in - t1_ff; dv_in = du_in - t2_ff;
         end
         default: begin
            du_in = lead_in; dw_in = du_in - t2_ff; dv_in = dw_in - t1_ff;
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         du_ff <= du_in; dv_ff <= dv_in; dw_ff <= dw_in;
         sec4_ff <= sec3_ff;
         z4_ff   <= z3_ff;
      end
   end

   // stage 5: clamp to 0..period
   function automatic logic [PERIOD_WIDTH-1:0] clamp(input logic signed [DW-1:0] d,
                                                     input logic [PERIOD_WIDTH-1:0] p);
      if (d < 0) return '0;
      if (d > $signed(DW'({1'b0, p}))) return p;
      return d[PERIOD_WIDTH-1:0];
   endfunction

   logic [PERIOD_WIDTH-1:0] u_ff, v_ff, w_ff;
   logic [2:0]              s_ff;
   logic                    z5_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         u_ff  <= z4_ff ? '0 : clamp(du_ff, period);
         v_ff  <= z4_ff ? '0 : clamp(dv_ff, period);
         w_ff  <= z4_ff ? '0 : clamp(dw_ff, period);
         s_ff  <= z4_ff ? svpwm_pkg::SECTOR_ZERO_BUS : 3'(sec4_ff);
         z5_ff <= z4_ff;
      end
   end

   assign out_valid = vld_ff[4];
   assign duty_u    = u_ff;
   assign duty_v    = v_ff;
   assign duty_w    = w_ff;
   assign sector    = s_ff;
   assign bus_zero  = z5_ff;
endmodule
